### hw/rtl/ncdf_pkg.sv
// Shared constants, types and helpers for the normal CDF pipeline.
`timescale 1ns / 1ps
package ncdf_pkg;

    // Internal fixed point: unsigned Q30 unless stated
    localparam int QB = 30;
    localparam int INPUT_FRAC_BITS_DEF  = 24;
    localparam int OUTPUT_FRAC_BITS_DEF = 24;

    // Field and datapath widths
    localparam int X_W   = 32;  // argument
    localparam int P_W   = 25;  // probability
    localparam int Z_W   = 33;  // z in Q30, below 8.0
    localparam int T_W   = 31;  // t at most 1.0
    localparam int E_W   = 31;  // exp term at most 1.0
    localparam int W_W   = 30;  // w = z^2/64, below 1.0
    localparam int ACC_W = 33;  // signed Horner accumulator
    localparam int POS_W = 32;  // clamped polynomial value
    localparam int DIV_W = 32;  // divider remainder / quotient

    localparam logic [63:0] Q_ONE  = 64'd1 << QB;
    localparam logic [63:0] Q_HALF = 64'd1 << (QB - 1);
    localparam logic [63:0] Z_SAT  = 64'd6 << QB;
    localparam logic [63:0] PRE_ONE = 64'd1 << 31;

    // Decimal constants scaled to Q30, rounded
    localparam logic [63:0] DEC_SCALE = 64'd1000000000;
    localparam logic [63:0] DEC_RND   = 64'd500000000;

    localparam logic [29:0] INV_ROOT2 =
        30'(((64'd707106781 << QB) + DEC_RND) / DEC_SCALE);
    localparam logic [28:0] COEF_P =
        29'(((64'd327591100 << QB) + DEC_RND) / DEC_SCALE);

    localparam logic [ACC_W-1:0] A1_MAG =
        ACC_W'(((64'd254829592 << QB) + DEC_RND) / DEC_SCALE);
    localparam logic [ACC_W-1:0] A2_MAG =
        ACC_W'(((64'd284496736 << QB) + DEC_RND) / DEC_SCALE);
    localparam logic [ACC_W-1:0] A3_MAG =
        ACC_W'(((64'd1421413741 << QB) + DEC_RND) / DEC_SCALE);
    localparam logic [ACC_W-1:0] A4_MAG =
        ACC_W'(((64'd1453152027 << QB) + DEC_RND) / DEC_SCALE);
    localparam logic [ACC_W-1:0] A5_MAG =
        ACC_W'(((64'd1061405429 << QB) + DEC_RND) / DEC_SCALE);

    localparam logic signed [ACC_W-1:0] COEF_A1 = $signed(A1_MAG);
    localparam logic signed [ACC_W-1:0] COEF_A2 = -$signed(A2_MAG);
    localparam logic signed [ACC_W-1:0] COEF_A3 = $signed(A3_MAG);
    localparam logic signed [ACC_W-1:0] COEF_A4 = -$signed(A4_MAG);
    localparam logic signed [ACC_W-1:0] COEF_A5 = $signed(A5_MAG);

    // Pipeline shape
    localparam int DIV_STEPS    = 2;   // quotient bits per stage
    localparam int DIV_STAGES   = DIV_W / DIV_STEPS;
    localparam logic [DIV_W-1:0] DIV_REM0 = DIV_W'(64'd1 << (2 * QB - DIV_W));
    localparam int HORNER_STEPS = 5;
    localparam int TAYLOR_TERMS = 11;
    localparam int SQUARINGS    = 6;

    localparam int POLY_LAT = 2 + DIV_STAGES + 2 * HORNER_STEPS;
    localparam int EXP_LAT  = 2 + 3 * TAYLOR_TERMS + 2 * SQUARINGS;
    localparam int POLY_DLY = EXP_LAT - POLY_LAT;

    // Flags that ride alongside the arithmetic
    typedef struct packed {
        logic neg;
        logic sat;
    } t_flags;

    // Constant added after each Horner multiply
    function automatic logic signed [ACC_W-1:0] horner_coef(input int k);
        logic signed [ACC_W-1:0] c;
        case (k)
            0:       c = COEF_A4;
            1:       c = COEF_A3;
            2:       c = COEF_A2;
            3:       c = COEF_A1;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

### hw/rtl/ncdf_poly.sv
// Reciprocal t = 1/(1+p*z) and the fifth-order polynomial times t.
`timescale 1ns / 1ps
module ncdf_poly
    import ncdf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [Z_W-1:0]   i_z,
    output logic [POS_W-1:0] o_acc
);

    // Denominator 1 + p*z
    logic [61:0]      r_pz;
    logic [DIV_W-1:0] r_den;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pz  <= 62'(i_z) * 62'(COEF_P);
            r_den <= DIV_W'(Q_ONE + ((64'(r_pz) + Q_HALF) >> QB));
        end
    end

    // Restoring divider, two quotient bits a stage: (2^60 + den/2) / den
    logic [DIV_W-1:0] r_drem [0:DIV_STAGES-1];
    logic [DIV_W-1:0] r_dquo [0:DIV_STAGES-1];
    logic [DIV_W-1:0] r_dnum [0:DIV_STAGES-2];
    logic [DIV_W-1:0] r_dden [0:DIV_STAGES-2];

    for (genvar d = 0; d < DIV_STAGES; d++) begin : g_div
        logic [DIV_W-1:0] rem_in, num_in, quo_in, den_in;
        logic [DIV_W-1:0] rem_nx, num_nx, quo_nx;
        logic [DIV_W:0]   shv;

        if (d == 0) begin : g_first
            assign rem_in = DIV_REM0;
            assign num_in = {1'b0, r_den[DIV_W-1:1]};
            assign quo_in = '0;
            assign den_in = r_den;
        end else begin : g_next
            assign rem_in = r_drem[d-1];
            assign num_in = r_dnum[d-1];
            assign quo_in = r_dquo[d-1];
            assign den_in = r_dden[d-1];
        end

        always_comb begin
            rem_nx = rem_in;
            num_nx = num_in;
            quo_nx = quo_in;
            shv    = '0;
            for (int s = 0; s < DIV_STEPS; s++) begin
                shv    = {rem_nx, num_nx[DIV_W-1]};
                num_nx = {num_nx[DIV_W-2:0], 1'b0};
                if (shv >= {1'b0, den_in}) begin
                    rem_nx = DIV_W'(shv - {1'b0, den_in});
                    quo_nx = {quo_nx[DIV_W-2:0], 1'b1};
                end else begin
                    rem_nx = shv[DIV_W-1:0];
                    quo_nx = {quo_nx[DIV_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_drem[d] <= rem_nx;
                r_dquo[d] <= quo_nx;
            end
        end

        if (d < DIV_STAGES - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_dnum[d] <= num_nx;
                    r_dden[d] <= den_in;
                end
            end
        end
    end

    // Horner in signed Q30, multiply stage then round/add stage
    logic [63:0]             r_hprod [0:HORNER_STEPS-1];
    logic                    r_hneg  [0:HORNER_STEPS-1];
    logic signed [ACC_W-1:0] r_acc   [0:HORNER_STEPS-1];
    logic [T_W-1:0]          r_ta    [0:HORNER_STEPS-2];
    logic [T_W-1:0]          r_tb    [0:HORNER_STEPS-2];

    for (genvar h = 0; h < HORNER_STEPS; h++) begin : g_hor
        localparam logic signed [ACC_W-1:0] CADD = horner_coef(h);
        logic signed [ACC_W-1:0] acc_in;
        logic [T_W-1:0]          t_in;
        logic [ACC_W-1:0]        mag;
        logic [ACC_W-1:0]        rnd;
        logic signed [ACC_W-1:0] term;

        if (h == 0) begin : g_first
            assign acc_in = COEF_A5;
            assign t_in   = r_dquo[DIV_STAGES-1][T_W-1:0];
        end else begin : g_next
            assign acc_in = r_acc[h-1];
            assign t_in   = r_tb[h-1];
        end

        assign mag  = acc_in[ACC_W-1] ? ACC_W'(-acc_in) : ACC_W'(acc_in);
        assign rnd  = ACC_W'((r_hprod[h] + Q_HALF) >> QB);
        assign term = r_hneg[h] ? -$signed(rnd) : $signed(rnd);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_hprod[h] <= 64'(mag) * 64'(t_in);
                r_hneg[h]  <= acc_in[ACC_W-1];
                r_acc[h]   <= term + CADD;
            end
        end

        if (h < HORNER_STEPS - 1) begin : g_tpass
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_ta[h] <= t_in;
                    r_tb[h] <= r_ta[h];
                end
            end
        end
    end

    // Negative polynomial clamps to zero
    assign o_acc = r_acc[HORNER_STEPS-1][ACC_W-1] ? '0
                                                  : r_acc[HORNER_STEPS-1][POS_W-1:0];

endmodule

### hw/rtl/ncdf_exp.sv
// exp(-z^2) by a Taylor series on z^2/64, then six squarings.
`timescale 1ns / 1ps
module ncdf_exp
    import ncdf_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [Z_W-1:0] i_z,
    output logic [E_W-1:0] o_e
);

    // s = z*z from (z/2)^2, then w = s/64 rounded
    logic [63:0]    r_sq;
    logic [W_W-1:0] r_w0;
    logic [64:0]    sq_rnd;
    logic [37:0]    w_sum;

    assign sq_rnd = {1'b0, r_sq} + (65'd1 << 27);
    assign w_sum  = {1'b0, sq_rnd[64:28]} + 38'd32;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq <= 64'(i_z[Z_W-1:1]) * 64'(i_z[Z_W-1:1]);
            r_w0 <= w_sum[W_W+5:6];
        end
    end

    // Taylor terms e = 1 - w*e/n, n from eleven down to one
    logic [60:0]    r_m   [0:TAYLOR_TERMS-1];
    logic [61:0]    r_d   [0:TAYLOR_TERMS-1];
    logic [E_W-1:0] r_e   [0:TAYLOR_TERMS-1];
    logic [W_W-1:0] r_wa  [0:TAYLOR_TERMS-2];
    logic [W_W-1:0] r_wb  [0:TAYLOR_TERMS-2];
    logic [W_W-1:0] r_wc  [0:TAYLOR_TERMS-2];

    for (genvar j = 0; j < TAYLOR_TERMS; j++) begin : g_tay
        localparam int N  = TAYLOR_TERMS - j;
        localparam int LN = $clog2(N);
        // Exact floor(v/N) for v below 2^30
        localparam logic [31:0] MN =
            32'(((64'd1 << (QB + LN)) + 64'(N) - 64'd1) / 64'(N));
        logic [E_W-1:0] e_in;
        logic [W_W-1:0] w_in;
        logic [W_W-1:0] v;

        if (j == 0) begin : g_first
            assign e_in = E_W'(Q_ONE);
            assign w_in = r_w0;
        end else begin : g_next
            assign e_in = r_e[j-1];
            assign w_in = r_wc[j-1];
        end

        assign v = W_W'((64'(r_m[j]) + Q_HALF) >> QB);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[j]  <= 61'(w_in) * 61'(e_in);
                r_d[j]  <= 62'(v) * 62'(MN);
                r_e[j]  <= E_W'(Q_ONE - (64'(r_d[j]) >> (QB + LN)));
            end
        end

        if (j < TAYLOR_TERMS - 1) begin : g_wpass
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_wa[j] <= w_in;
                    r_wb[j] <= r_wa[j];
                    r_wc[j] <= r_wb[j];
                end
            end
        end
    end

    // Six squarings undo the scaling by 64
    logic [61:0]    r_sp [0:SQUARINGS-1];
    logic [E_W-1:0] r_se [0:SQUARINGS-1];

    for (genvar k = 0; k < SQUARINGS; k++) begin : g_sqr
        logic [E_W-1:0] e_in;

        if (k == 0) begin : g_first
            assign e_in = r_e[TAYLOR_TERMS-1];
        end else begin : g_next
            assign e_in = r_se[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sp[k] <= 62'(e_in) * 62'(e_in);
                r_se[k] <= E_W'((64'(r_sp[k]) + Q_HALF) >> QB);
            end
        end
    end

    assign o_e = r_se[SQUARINGS-1];

endmodule

### hw/rtl/normal_cdf_approximation_core.sv
// Standard normal CDF of a signed fixed-point argument, fully pipelined.
// The 47-stage exponential path sets the depth from input transfer to result.
// Throughput: one item per cycle; the reciprocal is a 16-stage restoring divider.
// A stall on the output freezes the whole pipeline through one shared enable.
// Reset (synchronous, active low) clears the valid bits only.
`timescale 1ns / 1ps
module normal_cdf_approximation_core
    import ncdf_pkg::*;
#(
    parameter int INPUT_FRAC_BITS  = INPUT_FRAC_BITS_DEF,
    parameter int OUTPUT_FRAC_BITS = OUTPUT_FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic signed [X_W-1:0] i_x_value,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [P_W-1:0]        o_probability
);

    localparam int LAT   = 3 + EXP_LAT + 2;
    localparam int E_IDX = 2 + EXP_LAT;

    logic en;
    logic [LAT-1:0] r_vld;

    // Whole pipeline moves unless a finished result is held back
    assign en      = ~r_vld[LAT-1] | i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // Front end: magnitude, scaling by 1/sqrt(2), saturation test
    logic [X_W-1:0] r_x1;
    logic [61:0]    r_zp;
    logic           r_neg2;
    logic [Z_W-1:0] r_z;
    t_flags         r_flg3;
    logic [X_W-1:0] w_mag;
    logic [63:0]    w_zfull;

    assign w_mag   = r_x1[X_W-1] ? (~r_x1 + X_W'(1)) : r_x1;
    assign w_zfull = (64'(r_zp) + (64'd1 << (INPUT_FRAC_BITS - 1))) >> INPUT_FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x1       <= i_x_value;
            r_zp       <= 62'(w_mag) * 62'(INV_ROOT2);
            r_neg2     <= r_x1[X_W-1];
            r_z        <= w_zfull[Z_W-1:0];
            r_flg3.neg <= r_neg2;
            r_flg3.sat <= (w_zfull >= Z_SAT);
        end
    end

    // Polynomial and exponential run side by side
    logic [POS_W-1:0] w_acc;
    logic [E_W-1:0]   w_e;

    ncdf_poly u_poly (
        .i_clk (i_clk),
        .i_en  (en),
        .i_z   (r_z),
        .o_acc (w_acc)
    );

    ncdf_exp u_exp (
        .i_clk (i_clk),
        .i_en  (en),
        .i_z   (r_z),
        .o_e   (w_e)
    );

    // Align polynomial and flags with the exponential
    logic [POS_W-1:0] r_pd  [0:POLY_DLY-1];
    t_flags           r_flg [0:EXP_LAT-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pd[0]  <= w_acc;
            r_flg[0] <= r_flg3;
            for (int k = 1; k < POLY_DLY; k++) r_pd[k] <= r_pd[k-1];
            for (int k = 1; k < EXP_LAT; k++) r_flg[k] <= r_flg[k-1];
        end
    end

    // q = poly * exp, then fold in the sign and round to the output format
    logic [62:0]      r_fprod;
    t_flags           r_flg_f1;
    logic [P_W-1:0]   r_prob;
    logic [32:0]      w_q;
    logic [31:0]      w_qc;
    logic [31:0]      w_pre;
    logic [63:0]      w_res;
    logic [63:0]      w_fin;

    assign w_q   = 33'((64'(r_fprod) + Q_HALF) >> QB);
    assign w_qc  = (33'(PRE_ONE) < w_q) ? 32'(PRE_ONE) : w_q[31:0];
    assign w_pre = r_flg_f1.neg ? w_qc : 32'(PRE_ONE - 64'(w_qc));

    if (OUTPUT_FRAC_BITS > 31) begin : g_up
        assign w_res = 64'(w_pre) << (OUTPUT_FRAC_BITS - 31);
    end else if (OUTPUT_FRAC_BITS == 31) begin : g_same
        assign w_res = 64'(w_pre);
    end else begin : g_down
        localparam int SH = 31 - OUTPUT_FRAC_BITS;
        assign w_res = (64'(w_pre) + (64'd1 << (SH - 1))) >> SH;
    end

    // Large magnitude gives exactly 0 or 1.0
    assign w_fin = !r_flg_f1.sat ? w_res :
                   r_flg_f1.neg  ? 64'd0 : (64'd1 << OUTPUT_FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fprod  <= 63'(r_pd[POLY_DLY-1]) * 63'(w_e);
            r_flg_f1 <= r_flg[EXP_LAT-1];
            r_prob   <= w_fin[P_W-1:0];
        end
    end

    assign o_probability = r_prob;

    // Checks
    a_exp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[E_IDX] && !r_flg[EXP_LAT-1].sat) |-> (w_e <= E_W'(Q_ONE)))
        else $error("exponential term above one");

    a_prob_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((OUTPUT_FRAC_BITS > P_W - 1) ||
                     (64'(o_probability) <= (64'd1 << OUTPUT_FRAC_BITS))))
        else $error("probability above one");

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |=> $stable(r_vld))
        else $error("pipeline moved during stall");

endmodule
